@@ hw/rtl/xtea_bd_pkg.sv @@
// ----------------------------------------------------------------------------
// xtea_bd_pkg
// shared constants, types and functions of the xtea block decrypt pipeline
// ----------------------------------------------------------------------------
package xtea_bd_pkg;

  localparam int unsigned MaxRoundsDef = 64;
  localparam int unsigned WordW        = 32;
  localparam int unsigned BlockW       = 64;
  localparam int unsigned RndCfgW      = 7;
  localparam int unsigned RndCntW      = 8;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned NumKeys      = 4;

  localparam logic [WordW-1:0] Delta = 32'h9E37_79B9;

  localparam logic [CfgIdxW-1:0] RegKey0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRounds = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLittle = 3'd5;

  localparam logic [RndCfgW-1:0] RoundsRst = 7'd32;

  typedef logic [NumKeys-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] sum;
  } blk_t;

  function automatic logic [WordW-1:0] swap32(input logic [WordW-1:0] x);
    swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

@@ hw/rtl/xtea_block_decrypt.sv @@
// ----------------------------------------------------------------------------
// xtea_block_decrypt
// xtea ecb block decryption, one 64-bit block per cycle through a chain of
// half-step cells
// ----------------------------------------------------------------------------
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+------------------------------
//  input    | start_i, busy_o, cipher_block_i     | taken when start_i && !busy_o
//  result   | done_o, plain_block_o               | one-cycle strobe, no stall
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i    | written when cfg_we_i
//
//  the path is an entry stage, one cell per half-step and an output stage;
//  cells past round_count pass the item along
//  a new item may start every cycle, busy_o stays low
//  reset clears the valid chain and loads the register reset values
//  the receiver cannot stall; each result shows for exactly one cycle
// ----------------------------------------------------------------------------
module xtea_block_decrypt #(
  parameter int unsigned MAX_ROUNDS = xtea_bd_pkg::MaxRoundsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [xtea_bd_pkg::BlockW-1:0]      cipher_block_i,
  output logic                                done_o,
  output logic [xtea_bd_pkg::BlockW-1:0]      plain_block_o,
  input  logic                                cfg_we_i,
  input  logic [xtea_bd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [xtea_bd_pkg::WordW-1:0]       cfg_wdata_i
);
  import xtea_bd_pkg::*;

  localparam int unsigned NumCells = 2 * MAX_ROUNDS;
  localparam int unsigned Latency  = NumCells + 2;

  key_t               key_q;
  logic [RndCfgW-1:0] rounds_q;
  logic               little_q;
  logic [RndCntW-1:0] rounds_eff;
  logic [WordW-1:0]   sum_init;
  logic [WordW-1:0]   in_v0;
  logic [WordW-1:0]   in_v1;
  logic [WordW-1:0]   out_v0;
  logic [WordW-1:0]   out_v1;
  logic               accept;

  logic               valid_c [NumCells+1];
  blk_t               data_c  [NumCells+1];
  blk_t               entry_d;
  blk_t               entry_q;
  logic               entry_valid_q;
  logic               done_q;
  logic [BlockW-1:0]  plain_q;
  logic [BlockW-1:0]  plain_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      rounds_q <= RoundsRst;
      little_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKey0:   key_q[0] <= cfg_wdata_i;
        RegKey1:   key_q[1] <= cfg_wdata_i;
        RegKey2:   key_q[2] <= cfg_wdata_i;
        RegKey3:   key_q[3] <= cfg_wdata_i;
        RegRounds: rounds_q <= cfg_wdata_i[RndCfgW-1:0];
        RegLittle: little_q <= cfg_wdata_i[0];
        default:   ;
      endcase
    end
  end

  assign rounds_eff = ({1'b0, rounds_q} > RndCntW'(MAX_ROUNDS)) ?
                      RndCntW'(MAX_ROUNDS) : {1'b0, rounds_q};
  assign sum_init   = Delta * WordW'(rounds_eff);

  // entry stage
  assign in_v0 = little_q ? swap32(cipher_block_i[BlockW-1:WordW])
                          : cipher_block_i[BlockW-1:WordW];
  assign in_v1 = little_q ? swap32(cipher_block_i[WordW-1:0])
                          : cipher_block_i[WordW-1:0];

  always_comb begin
    entry_d.v0  = in_v0;
    entry_d.v1  = in_v1;
    entry_d.sum = sum_init;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else begin
      entry_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

  assign valid_c[0] = entry_valid_q;
  assign data_c[0]  = entry_q;

  // cell chain
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    xtea_bd_cell #(
      .RoundIdx   (k / 2),
      .SecondHalf ((k % 2) == 1)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_c[k]),
      .data_i   (data_c[k]),
      .key_i    (key_q),
      .rounds_i (rounds_eff),
      .valid_o  (valid_c[k+1]),
      .data_o   (data_c[k+1])
    );
  end

  // output stage
  assign out_v0  = little_q ? swap32(data_c[NumCells].v0) : data_c[NumCells].v0;
  assign out_v1  = little_q ? swap32(data_c[NumCells].v1) : data_c[NumCells].v1;
  assign plain_d = {out_v0, out_v1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_c[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_c[NumCells]) begin
      plain_q <= plain_d;
    end
  end

  assign done_o        = done_q;
  assign plain_block_o = plain_q;

`ifndef SYNTHESIS
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without a started item");

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("started item produced no result");

  a_chain_end_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_c[NumCells] |=> done_o)
    else $error("last cell item not delivered");
`endif

endmodule

@@ hw/rtl/xtea_bd_cell.sv @@
// ----------------------------------------------------------------------------
// xtea_bd_cell
// one feistel half-step of the decrypt chain, registered
// ----------------------------------------------------------------------------
module xtea_bd_cell #(
  parameter int unsigned RoundIdx   = 0,
  parameter bit          SecondHalf = 1'b0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  xtea_bd_pkg::blk_t                      data_i,
  input  xtea_bd_pkg::key_t                      key_i,
  input  logic [xtea_bd_pkg::RndCntW-1:0]        rounds_i,
  output logic                                   valid_o,
  output xtea_bd_pkg::blk_t                      data_o
);
  import xtea_bd_pkg::*;

  logic             active;
  logic [1:0]       key_sel;
  logic [WordW-1:0] mixed;
  logic [WordW-1:0] keyed;
  blk_t             data_d;
  blk_t             data_q;
  logic             valid_q;

  assign active  = rounds_i > RndCntW'(RoundIdx);
  assign key_sel = SecondHalf ? data_i.sum[1:0] : data_i.sum[12:11];
  assign mixed   = SecondHalf ? mix(data_i.v1) : mix(data_i.v0);
  assign keyed   = mixed ^ (data_i.sum + key_i[key_sel]);

  always_comb begin
    data_d = data_i;
    if (active) begin
      if (SecondHalf) begin
        data_d.v0 = data_i.v0 - keyed;
      end else begin
        data_d.v1  = data_i.v1 - keyed;
        data_d.sum = data_i.sum - Delta;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  a_idle_cell_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !active |=> data_q == $past(data_i))
    else $error("inactive cell changed the item");

  a_valid_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |=> valid_o)
    else $error("item dropped by cell");

  a_no_valid_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |=> !valid_o)
    else $error("cell produced an item from nothing");
`endif

endmodule
